// ----- design/sstq_pkg.sv -----
// Shared types and codes for the sorted software timer queue.
package sstq_pkg;

  // Most expiries that one tick may report; later due timers wait for the next tick.
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_TICK   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_ZERO_TIME = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_TICK_NONE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] timeout_ticks;
    logic [15:0] handler_id;
    logic [31:0] arg_token;
    logic [3:0]  handle_in;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  handle_out;
    logic [15:0] handler_out;
    logic [31:0] arg_out;
    logic [31:0] tick_now;
    logic        last;
  } out_t;

  // One timer as it sits in the sorted chain; the slot number travels beside it.
  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [15:0] handler;
    logic [31:0] arg;
  } ent_t;

endpackage

// ----- design/sstq_cell.sv -----
// One position of the deadline-sorted timer chain.
module sstq_cell #(
  parameter int SLOT_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  sstq_pkg::cell_op_t  op,
  input  logic                keep_left,
  input  logic                take_right_en,
  input  sstq_pkg::ent_t      new_ent,
  input  logic [SLOT_W-1:0]   new_slot,
  input  sstq_pkg::ent_t      left_ent,
  input  logic [SLOT_W-1:0]   left_slot,
  input  sstq_pkg::ent_t      right_ent,
  input  logic [SLOT_W-1:0]   right_slot,
  output sstq_pkg::ent_t      ent,
  output logic [SLOT_W-1:0]   slot,
  output logic                keep
);
  import sstq_pkg::*;

  ent_t              ent_next;
  logic [SLOT_W-1:0] slot_next;

  // A strictly earlier deadline stays put, so a new timer lands ahead of equal ones.
  assign keep = ent.valid && (ent.deadline < new_ent.deadline);

  always_comb begin
    ent_next  = ent;
    slot_next = slot;
    case (op)
      CELL_INSERT: begin
        if (!keep) begin
          if (keep_left) begin
            ent_next  = new_ent;
            slot_next = new_slot;
          end else begin
            ent_next  = left_ent;
            slot_next = left_slot;
          end
        end
      end
      CELL_REMOVE: begin
        if (take_right_en) begin
          ent_next  = right_ent;
          slot_next = right_slot;
        end
      end
      CELL_POP: begin
        ent_next  = right_ent;
        slot_next = right_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
    slot <= slot_next;
  end

endmodule

// ----- design/sorted_software_timer_queue_top.sv -----
// Top level of the sorted software timer queue: control, slot map and cell chain.
//
//   channel   signals                     direction  payload
//   in        in_valid / in_ready         to block   in_data  (sstq_pkg::in_t)
//   out       out_valid / out_ready       from block out_data (sstq_pkg::out_t)
//
// Create and delete finish in the transfer cycle; the result is registered at that edge.
// A tick first advances the count, then loads one result a cycle while the output is free (1 to 16
// results), each expiry popped from the head of the cell chain.
// A new item is taken only once the previous item's last result has been transferred.
// Reset clears the tick count, the slot map and every cell's valid bit.
// A stalled output holds its register and pauses the expiry sequence.
module sorted_software_timer_queue_top #(
  parameter int NUM_TIMERS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sstq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sstq_pkg::out_t  out_data
);
  import sstq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_TIMERS);

  typedef enum logic {S_IDLE, S_TICK} state_t;

  state_t                 state;
  logic [31:0]            tick_count;
  logic [NUM_TIMERS-1:0]  slot_valid;
  logic [RES_CNT_W-1:0]   res_cnt;

  ent_t                   cell_ent   [NUM_TIMERS];
  logic [SLOT_W-1:0]      cell_slot  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  cell_keep;
  logic [NUM_TIMERS-1:0]  cell_valid;
  logic [NUM_TIMERS-1:0]  take_right;

  ent_t                   new_ent;
  ent_t                   empty_ent;
  logic [SLOT_W-1:0]      free_slot;
  logic [SLOT_W-1:0]      del_slot;
  logic [SLOT_W-1:0]      del_pos;
  logic                   accept;
  logic                   out_free;
  logic                   full;
  logic                   del_found;
  logic                   head_due;
  logic                   next_due;
  logic                   pop;
  logic                   final_res;
  cell_op_t               op;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = cell_ent[NUM_TIMERS-1].valid;

  assign new_ent.valid    = 1'b1;
  assign new_ent.deadline = tick_count + in_data.timeout_ticks;
  assign new_ent.handler  = in_data.handler_id;
  assign new_ent.arg      = in_data.arg_token;

  assign empty_ent = '0;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign del_slot  = SLOT_W'(in_data.handle_in);
  assign del_found = (32'(in_data.handle_in) < NUM_TIMERS) && slot_valid[del_slot];

  // Chain position of the timer being deleted; cells from there on shift left.
  always_comb begin
    del_pos = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (cell_ent[i].valid && (cell_slot[i] == del_slot)) begin
        del_pos = SLOT_W'(i);
      end
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      take_right[i] = (SLOT_W'(i) >= del_pos);
    end
  end

  assign head_due  = cell_ent[0].valid && (cell_ent[0].deadline <= tick_count);
  assign next_due  = cell_ent[1].valid && (cell_ent[1].deadline <= tick_count);
  assign pop       = (state == S_TICK) && out_free && head_due;
  assign final_res = (res_cnt == RES_CNT_W'(MAX_RESULTS - 1)) || !next_due;

  always_comb begin
    op = CELL_HOLD;
    if (accept && (in_data.mode == MODE_CREATE) && (in_data.timeout_ticks != '0) && !full) begin
      op = CELL_INSERT;
    end else if (accept && (in_data.mode == MODE_DELETE) && del_found) begin
      op = CELL_REMOVE;
    end else if (pop) begin
      op = CELL_POP;
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    ent_t              left_ent;
    logic [SLOT_W-1:0] left_slot;
    logic              keep_left;
    ent_t              right_ent;
    logic [SLOT_W-1:0] right_slot;

    if (i == 0) begin : g_head
      assign left_ent  = new_ent;
      assign left_slot = free_slot;
      assign keep_left = 1'b1;
    end else begin : g_body
      assign left_ent  = cell_ent[i-1];
      assign left_slot = cell_slot[i-1];
      assign keep_left = cell_keep[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign right_ent  = empty_ent;
      assign right_slot = '0;
    end else begin : g_mid
      assign right_ent  = cell_ent[i+1];
      assign right_slot = cell_slot[i+1];
    end

    sstq_cell #(
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .keep_left    (keep_left),
      .take_right_en(take_right[i]),
      .new_ent      (new_ent),
      .new_slot     (free_slot),
      .left_ent     (left_ent),
      .left_slot    (left_slot),
      .right_ent    (right_ent),
      .right_slot   (right_slot),
      .ent          (cell_ent[i]),
      .slot         (cell_slot[i]),
      .keep         (cell_keep[i])
    );

    assign cell_valid[i] = cell_ent[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      tick_count <= '0;
      slot_valid <= '0;
      res_cnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            out_data.handler_out <= '0;
            out_data.arg_out     <= '0;
            out_data.tick_now    <= tick_count;
            out_data.last        <= 1'b1;
            unique case (in_data.mode)
              MODE_CREATE: begin
                out_valid <= 1'b1;
                if (in_data.timeout_ticks == '0) begin
                  out_data.status     <= ST_ZERO_TIME;
                  out_data.handle_out <= '0;
                end else if (full) begin
                  out_data.status     <= ST_FULL;
                  out_data.handle_out <= '0;
                end else begin
                  out_data.status     <= ST_CREATED;
                  out_data.handle_out <= 4'(free_slot);
                  slot_valid[free_slot] <= 1'b1;
                end
              end
              MODE_DELETE: begin
                out_valid <= 1'b1;
                if (del_found) begin
                  out_data.status     <= ST_DELETED;
                  out_data.handle_out <= in_data.handle_in;
                  slot_valid[del_slot] <= 1'b0;
                end else begin
                  out_data.status     <= ST_NOT_FOUND;
                  out_data.handle_out <= '0;
                end
              end
              MODE_TICK: begin
                tick_count <= tick_count + 32'd1;
                res_cnt    <= '0;
                state      <= S_TICK;
              end
              default: begin
              end
            endcase
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_TICK: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.tick_now <= tick_count;
            if (head_due) begin
              out_data.status      <= ST_EXPIRED;
              out_data.handle_out  <= 4'(cell_slot[0]);
              out_data.handler_out <= cell_ent[0].handler;
              out_data.arg_out     <= cell_ent[0].arg;
              out_data.last        <= final_res;
              slot_valid[cell_slot[0]] <= 1'b0;
              res_cnt <= res_cnt + RES_CNT_W'(1);
              if (final_res) begin
                state <= S_IDLE;
              end
            end else begin
              // Only reached on the first step: nothing was due on this tick.
              out_data.status      <= ST_TICK_NONE;
              out_data.handle_out  <= '0;
              out_data.handler_out <= '0;
              out_data.arg_out     <= '0;
              out_data.last        <= 1'b1;
              state                <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Occupied cells always form an unbroken run from the head.
  for (genvar i = 0; i < NUM_TIMERS - 1; i++) begin : g_chk
    a_prefix: assert property (@(posedge clk) disable iff (rst)
      !cell_valid[i] |-> !cell_valid[i+1])
      else $error("gap in timer chain");
  end

  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == $countones(cell_valid))
    else $error("slot map and chain disagree");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> (res_cnt < RES_CNT_W'(MAX_RESULTS)))
    else $error("too many expiries on one tick");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (state == S_TICK))
    else $error("non-final result with no tick in progress");

endmodule
